// ===== design/crcpb_pkg.sv =====
// Shared types, constants and CRC-8 step function for the framed packet builder.
package crcpb_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 1'b1;

	localparam logic [7:0] START_MARKER_RESET = 8'h16;
	localparam logic [7:0] CRC_POLY_RESET     = 8'h07;

	typedef struct packed {
		logic       first_of_packet;
		logic [7:0] msg_type;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
	} out_item_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic       open_pkt;   // emit header before the payload byte
		logic       last;       // CRC closes the packet after this command
		logic [7:0] msg_type;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_TYPE,
		PH_LEN,
		PH_PAY,
		PH_CRC
	} phase_t;

	// MSB-first CRC-8 over one byte, x^8 implied
	function automatic logic [7:0] crc8_update(
		input logic [7:0] crc,
		input logic [7:0] data,
		input logic [7:0] poly
	);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/crcpb_front.sv =====
// Front end: accepts input items, drops strays, tracks packet state, queues commands.
module crcpb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  crcpb_pkg::in_item_t src_item,
	input  logic              q_full,
	output logic              push,
	output crcpb_pkg::cmd_t   push_cmd
);
	import crcpb_pkg::*;

	logic       packet_open_q;
	logic [7:0] bytes_remaining_q;
	logic       accept;
	logic       keep;
	logic       last;
	logic [7:0] rem_d;

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;
	assign keep      = src_item.first_of_packet || packet_open_q;

	always_comb begin
		if (src_item.first_of_packet) begin
			rem_d = src_item.payload_length - 8'd1;
			last  = (src_item.payload_length == 8'd0) || (src_item.payload_length == 8'd1);
		end else begin
			rem_d = bytes_remaining_q - 8'd1;
			last  = (bytes_remaining_q == 8'd1);
		end
	end

	assign push                    = accept && keep;
	assign push_cmd.open_pkt       = src_item.first_of_packet;
	assign push_cmd.last           = last;
	assign push_cmd.msg_type       = src_item.msg_type;
	assign push_cmd.payload_length = src_item.payload_length;
	assign push_cmd.payload_byte   = src_item.payload_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_open_q     <= 1'b0;
			bytes_remaining_q <= 8'd0;
		end else if (push) begin
			packet_open_q     <= !last;
			bytes_remaining_q <= rem_d;
		end
	end

endmodule

// ===== design/crcpb_fifo.sv =====
// Small command queue between front and back.
module crcpb_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  crcpb_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output crcpb_pkg::cmd_t head
);
	import crcpb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == DEPTH_C);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/crcpb_back.sv =====
// Back end: walks each command through its bytes, runs the CRC, drives the output register.
module crcpb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  crcpb_pkg::cmd_t      head,
	output logic                 pop,
	input  logic [7:0]           start_marker,
	input  logic [7:0]           crc_polynomial,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output crcpb_pkg::out_item_t dst_item
);
	import crcpb_pkg::*;

	phase_t     phase_q, phase_d, cur;
	logic [7:0] crc_q, crc_d;
	logic       step;
	logic       done;
	out_item_t  item_d;
	out_item_t  out_q;
	logic       out_valid_q;

	assign step = head_valid && (!out_valid_q || !dst_stall);
	assign pop  = step && done;

	always_comb begin
		// a follow-on command starts straight at its payload byte
		cur     = (phase_q == PH_START && !head.open_pkt) ? PH_PAY : phase_q;
		phase_d = phase_q;
		crc_d   = crc_q;
		done    = 1'b0;
		item_d.end_of_packet = 1'b0;
		item_d.out_byte      = head.payload_byte;
		unique case (cur)
			PH_START: begin
				item_d.out_byte = start_marker;
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				item_d.out_byte = head.msg_type;
				crc_d   = crc8_update(8'h00, head.msg_type, crc_polynomial);
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				item_d.out_byte = head.payload_length;
				crc_d   = crc8_update(crc_q, head.payload_length, crc_polynomial);
				phase_d = (head.payload_length == 8'd0) ? PH_CRC : PH_PAY;
			end
			PH_PAY: begin
				item_d.out_byte = head.payload_byte;
				crc_d = crc8_update(crc_q, head.payload_byte, crc_polynomial);
				if (head.last) begin
					phase_d = PH_CRC;
				end else begin
					phase_d = PH_START;
					done    = 1'b1;
				end
			end
			PH_CRC: begin
				item_d.out_byte      = crc_q;
				item_d.end_of_packet = 1'b1;
				phase_d = PH_START;
				done    = 1'b1;
			end
			default: begin
				phase_d = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				crc_q   <= crc_d;
			end
			out_valid_q <= step || (out_valid_q && dst_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= item_d;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

endmodule

// ===== design/crc8_packet_frame_builder.sv =====
// Top level of the CRC-8 framed packet builder: config registers, front, queue, back.
//
// Usage:
//  - Input channel (src_valid / src_stall / src_item): one transaction per item. An item with
//    first_of_packet set opens a packet (type, length, and the first payload byte if the
//    length is nonzero); each later item carries one payload byte. Items without
//    first_of_packet while no packet is open are dropped. A new opener abandons an open
//    packet without its CRC.
//  - Output channel (dst_valid / dst_stall / dst_item): one framed byte per transaction:
//    start marker, type, length, payload, then the CRC-8 byte with end_of_packet set.
//  - Config port (cfg_we / cfg_index / cfg_data): index 0 start marker, index 1 CRC
//    polynomial. Write only while the block is idle.
//  - Path: an item is written into the command queue, then its first byte into the output register.
//  - Throughput: the back end emits one byte per cycle unless stalled or out of commands;
//    its sequencer puts marker, type and length before an opener's payload, the CRC after a
//    closing item. Input is taken every cycle until the QUEUE_DEPTH-entry command queue fills.
//  - Reset: start marker 0x16, polynomial 0x07, no packet open, queue and output empty.
//  - Stall: dst_stall holds the output register; the back end stops, the queue fills,
//    then src_stall rises. Nothing is lost or repeated.
module crc8_packet_frame_builder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  src_valid,
	output logic                                  src_stall,
	input  crcpb_pkg::in_item_t                   src_item,
	output logic                                  dst_valid,
	input  logic                                  dst_stall,
	output crcpb_pkg::out_item_t                  dst_item,
	input  logic                                  cfg_we,
	input  logic [crcpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [crcpb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import crcpb_pkg::*;

	logic [7:0] start_marker_val_q;
	logic [7:0] crc_poly_q;

	logic       push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       pop;
	logic       head_valid;
	cmd_t       head;

	// config registers; the user must hold them stable while traffic runs, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_val_q <= START_MARKER_RESET;
			crc_poly_q         <= CRC_POLY_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START_MARKER:   start_marker_val_q <= cfg_data;
					REG_CRC_POLYNOMIAL: crc_poly_q         <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	crcpb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	crcpb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	crcpb_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.start_marker   (start_marker_val_q),
		.crc_polynomial (crc_poly_q),
		.dst_valid      (dst_valid),
		.dst_stall      (dst_stall),
		.dst_item       (dst_item)
	);

endmodule
